FILE: sv/mscdt_pkg.sv
package mscdt_pkg;

  localparam int NUM_SLOTS_DEF = 16;
  localparam int TICK_STEP = 1;

  localparam logic [1:0] FUNC_START = 2'd0;
  localparam logic [1:0] FUNC_STOP  = 2'd1;
  localparam logic [1:0] FUNC_TICK  = 2'd2;

  localparam logic [1:0] KIND_START     = 2'd0;
  localparam logic [1:0] KIND_STOP      = 2'd1;
  localparam logic [1:0] KIND_EXPIRY    = 2'd2;
  localparam logic [1:0] KIND_TICK_DONE = 2'd3;

  typedef struct packed {
    logic [1:0]  func;
    logic [3:0]  slot;
    logic [31:0] period;
    logic        one_shot;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] slot_id;
    logic       status;
    logic       last;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic do_op;
    logic cnt_clr;
    logic cnt_inc;
    logic mem_rd;
    logic tick_commit;
    logic emit_done;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
    logic cur_armed;
    logic cnt_last;
    logic expire;
  } dp_stat_t;

endpackage

FILE: sv/mscdt_ctrl.sv
module mscdt_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [1:0]           in_func,
  input  mscdt_pkg::dp_stat_t  stat,
  output logic                 in_stall,
  output mscdt_pkg::ctl_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_EVAL = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       accept;

  assign in_stall = !((state == S_IDLE) && stat.out_free);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.do_op = 1'b1;
          if (in_func == mscdt_pkg::FUNC_TICK) begin
            cmd.cnt_clr = 1'b1;
            state_next  = S_READ;
          end
        end
      end
      S_READ: begin
        // Unarmed slots are skipped without a memory read.
        if (stat.cur_armed) begin
          cmd.mem_rd = 1'b1;
          state_next = S_EVAL;
        end else if (stat.cnt_last) begin
          state_next = S_DONE;
        end else begin
          cmd.cnt_inc = 1'b1;
        end
      end
      S_EVAL: begin
        if (!stat.expire || stat.out_free) begin
          cmd.tick_commit = 1'b1;
          if (stat.cnt_last) begin
            state_next = S_DONE;
          end else begin
            cmd.cnt_inc = 1'b1;
            state_next  = S_READ;
          end
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.emit_done = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: sv/mscdt_dp.sv
module mscdt_dp #(
  parameter int NUM_SLOTS = mscdt_pkg::NUM_SLOTS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  mscdt_pkg::in_item_t  in_data,
  input  mscdt_pkg::ctl_cmd_t  cmd,
  input  logic                 out_stall,
  output mscdt_pkg::dp_stat_t  stat,
  output logic                 out_valid,
  output mscdt_pkg::out_item_t out_data
);

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [31:0] STEP = 32'(mscdt_pkg::TICK_STEP);

  logic [IDX_W-1:0]     cnt;
  logic [NUM_SLOTS-1:0] armed;

  // Per-slot mode and period {single, reload}, and the running count.
  logic [32:0] cfg_mem [NUM_SLOTS];
  logic [31:0] rem_mem [NUM_SLOTS];
  logic [32:0] cfg_rd;
  logic [31:0] rem_rd;

  logic [IDX_W-1:0] in_idx;
  logic             in_ok;
  logic             is_start;
  logic             is_stop;
  logic             start_ok;
  logic             stop_ok;
  logic             expire;

  logic             rem_we;
  logic [IDX_W-1:0] rem_wa;
  logic [31:0]      rem_wd;

  logic                 load_out;
  mscdt_pkg::out_item_t out_next;

  assign in_idx   = IDX_W'(in_data.slot);
  assign in_ok    = 32'(in_data.slot) < NUM_SLOTS;
  assign is_start = cmd.do_op && (in_data.func == mscdt_pkg::FUNC_START);
  assign is_stop  = cmd.do_op && (in_data.func == mscdt_pkg::FUNC_STOP);
  assign start_ok = is_start && in_ok && (in_data.period != 32'd0);
  assign stop_ok  = is_stop && in_ok && armed[in_idx];
  assign expire   = rem_rd <= STEP;

  assign stat.out_free  = !out_valid || !out_stall;
  assign stat.cur_armed = armed[cnt];
  assign stat.cnt_last  = cnt == IDX_W'(NUM_SLOTS - 1);
  assign stat.expire    = expire;

  always_comb begin
    rem_we = 1'b0;
    rem_wa = cnt;
    rem_wd = rem_rd - STEP;
    if (start_ok) begin
      rem_we = 1'b1;
      rem_wa = in_idx;
      rem_wd = in_data.period;
    end else if (cmd.tick_commit) begin
      if (!expire) begin
        rem_we = 1'b1;
      end else if (!cfg_rd[32]) begin
        rem_we = 1'b1;
        rem_wd = cfg_rd[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_ok) begin
      cfg_mem[in_idx] <= {in_data.one_shot, in_data.period};
    end
    if (rem_we) begin
      rem_mem[rem_wa] <= rem_wd;
    end
    if (cmd.mem_rd) begin
      cfg_rd <= cfg_mem[cnt];
      rem_rd <= rem_mem[cnt];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt   <= '0;
      armed <= '0;
    end else begin
      if (cmd.cnt_clr) begin
        cnt <= '0;
      end else if (cmd.cnt_inc) begin
        cnt <= cnt + 1'b1;
      end
      if (start_ok) begin
        armed[in_idx] <= 1'b1;
      end else if (stop_ok) begin
        armed[in_idx] <= 1'b0;
      end else if (cmd.tick_commit && expire && cfg_rd[32]) begin
        armed[cnt] <= 1'b0;
      end
    end
  end

  always_comb begin
    load_out = 1'b0;
    out_next = '0;
    if (is_start) begin
      load_out         = 1'b1;
      out_next.kind    = mscdt_pkg::KIND_START;
      out_next.slot_id = in_data.slot;
      out_next.status  = !start_ok;
      out_next.last    = 1'b1;
    end else if (is_stop) begin
      load_out         = 1'b1;
      out_next.kind    = mscdt_pkg::KIND_STOP;
      out_next.slot_id = in_data.slot;
      out_next.status  = !stop_ok;
      out_next.last    = 1'b1;
    end else if (cmd.tick_commit && expire) begin
      load_out         = 1'b1;
      out_next.kind    = mscdt_pkg::KIND_EXPIRY;
      out_next.slot_id = 4'(cnt);
    end else if (cmd.emit_done) begin
      load_out      = 1'b1;
      out_next.kind = mscdt_pkg::KIND_TICK_DONE;
      out_next.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data <= out_next;
    end
  end

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    load_out |-> stat.out_free)
    else $error("result loaded over an untaken result");

  a_start_arms: assert property (@(posedge clk) disable iff (rst)
    start_ok |=> armed[$past(in_idx)])
    else $error("successful start did not arm its slot");

  a_one_op: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.do_op, cmd.tick_commit, cmd.emit_done}))
    else $error("operation and tick scan overlap");

endmodule

FILE: sv/multi_slot_countdown_timer_top.sv
// Bank of countdown timer slots. A start transfer loads a slot with a period
// and a one-shot or periodic mode and arms it; a zero period or a slot beyond
// the bank is refused with error status. A stop transfer disarms an armed
// slot and reports an error for an unarmed one. A tick transfer walks every
// slot in ascending order with one shared decrementer: an unarmed slot is
// skipped without a memory read and an armed slot takes a registered memory
// read, then the update. A tick ends with one tick-done result, takes no new
// transfer until then and waits while the output is stalled. Every slot that
// reaches zero gives an expiry result, then is disarmed (one-shot) or
// reloaded (periodic). Start and stop finish in the cycle they are taken,
// one result each.
module multi_slot_countdown_timer_top #(
  parameter int NUM_SLOTS = mscdt_pkg::NUM_SLOTS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  mscdt_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output mscdt_pkg::out_item_t out_data
);

  mscdt_pkg::ctl_cmd_t cmd;
  mscdt_pkg::dp_stat_t stat;

  // The controller sequences the tick scan and gates input transfers.
  mscdt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_func  (in_data.func),
    .stat     (stat),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  // The datapath holds the slot state, the scan counter and the output
  // register that decouples results from the input side.
  mscdt_dp #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .out_stall (out_stall),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
